// File: sv/hbfe_pkg.sv
// ----------------------------------------------------------------------------
// hbfe_pkg
// shared types, codes and saturating helpers for the harmonic bond unit
// ----------------------------------------------------------------------------
package hbfe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ATOM_W    = 12;

  // result kinds
  localparam logic [3:0] KIND_FORCE  = 4'd0;
  localparam logic [3:0] KIND_ENERGY = 4'd1;
  localparam logic [3:0] KIND_VIR_ZZ = 4'd10;

  // register indexes
  localparam logic [2:0] REG_BOX_X  = 3'd0;
  localparam logic [2:0] REG_BOX_Y  = 3'd1;
  localparam logic [2:0] REG_BOX_Z  = 3'd2;
  localparam logic [2:0] REG_HALF_X = 3'd3;
  localparam logic [2:0] REG_HALF_Y = 3'd4;
  localparam logic [2:0] REG_HALF_Z = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEP, ST_SQ, ST_SQRT, ST_KD, ST_EN, ST_DE,
    ST_H1, ST_H2, ST_F, ST_VIR, ST_FORCE, ST_TOT
  } st_t;

  typedef enum logic [1:0] {OP_MUL, OP_MULF, OP_DIV} op_t;

  typedef enum logic [1:0] {MS_IDLE, MS_MUL, MS_DIV, MS_FIN} ms_t;

  typedef struct packed {
    logic               start;
    op_t                op;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [31:0]        divisor;
  } md_req_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] x);
    if (x == {1'b1, 63'b0}) begin
      sat_neg = {1'b0, {63{1'b1}}};
    end else begin
      sat_neg = -x;
    end
  endfunction

endpackage

// File: sv/hbfe_sqrt.sv
// ----------------------------------------------------------------------------
// hbfe_sqrt
// integer square root of a 64-bit value, two radicand bits per cycle
// ----------------------------------------------------------------------------
module hbfe_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import hbfe_pkg::*;

  logic        busy_r;
  logic [63:0] v_r, res_r, bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign done  = busy_r && (bit_r == 64'd0);
  assign root  = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= 64'd0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r && bit_r != 64'd0) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// File: sv/hbfe_muldiv.sv
// ----------------------------------------------------------------------------
// hbfe_muldiv
// bit-serial signed multiply, then optional shift or restoring divide
// ----------------------------------------------------------------------------
module hbfe_muldiv (
  input  logic               clk,
  input  logic               rst_n,
  input  hbfe_pkg::md_req_t  req,
  output logic               done,
  output logic signed [63:0] result
);
  import hbfe_pkg::*;

  ms_t          st_r, st_nxt;
  op_t          op_r;
  logic         neg_r;
  logic [63:0]  ma_r;
  logic [31:0]  dv_r;
  logic [127:0] p_r;
  logic [31:0]  rem_r;
  logic [6:0]   cnt_r;
  logic [64:0]  msum;
  logic [32:0]  rem_s;
  logic         take;
  logic [127:0] q;

  assign msum  = {1'b0, p_r[127:64]} + (p_r[0] ? {1'b0, ma_r} : 65'd0);
  assign rem_s = {rem_r, p_r[127]};
  assign take  = rem_s >= {1'b0, dv_r};
  assign q     = (op_r == OP_MULF) ? (p_r >> FRAC_BITS) : p_r;

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    unique case (st_r)
      MS_IDLE: if (req.start) st_nxt = MS_MUL;
      MS_MUL:  if (cnt_r == 7'd63) st_nxt = (op_r == OP_DIV) ? MS_DIV : MS_FIN;
      MS_DIV:  if (cnt_r == 7'd127) st_nxt = MS_FIN;
      MS_FIN: begin
        done   = 1'b1;
        st_nxt = MS_IDLE;
      end
      default: st_nxt = MS_IDLE;
    endcase
  end

  always_comb begin
    if (neg_r) begin
      if (q[127:63] != 65'd0) result = {1'b1, 63'b0};
      else                    result = -$signed(q[63:0]);
    end else begin
      if (q[127:63] != 65'd0) result = {1'b0, {63{1'b1}}};
      else                    result = $signed(q[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= MS_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      MS_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          neg_r <= req.a[63] != req.b[63];
          ma_r  <= req.a[63] ? (~req.a + 64'd1) : req.a;
          p_r   <= {64'd0, (req.b[63] ? (~req.b + 64'd1) : req.b)};
          dv_r  <= req.divisor;
          cnt_r <= 7'd0;
        end
      end
      MS_MUL: begin
        p_r   <= {msum, p_r[63:1]};
        rem_r <= 32'd0;
        cnt_r <= (cnt_r == 7'd63) ? 7'd0 : cnt_r + 7'd1;
      end
      MS_DIV: begin
        rem_r <= take ? 32'(rem_s - {1'b0, dv_r}) : rem_s[31:0];
        p_r   <= {p_r[126:0], take};
        cnt_r <= cnt_r + 7'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/harmonic_bond_force_energy.sv
// ----------------------------------------------------------------------------
// harmonic_bond_force_energy
// harmonic bond force, energy, hessian diagonal and virial unit
// ----------------------------------------------------------------------------
// usage: write box and half lengths on the cfg port while idle, then stream
// one bond per in item (in_tlast marks the last bond of the set). every bond
// gives one force record (out_tuser = 0); after a last bond the ten totals
// follow (energy, hessian x..z, virial xx..zz) and are cleared.
// out_tlast is 1 on a force record of a non-last bond and on the final total.
// flow: one bond at a time, in_tready is high only while idle. the cost is
// set by the one shared bit-serial multiply/divide unit and the square root
// unit. with r > 0 the force record follows three squares, the root, k*dev,
// the energy, a derivative quotient, two quotients per hessian axis, three
// force quotients and six virial products; with r = 0 it follows the energy.
// the next bond can be accepted once the force record of a non-last bond
// is valid. a stalled receiver holds the output register; the next bond is
// accepted while a force record waits, and processing only blocks when a new
// record must be written. synchronous reset clears config, control, totals.
// ----------------------------------------------------------------------------
module harmonic_bond_force_energy (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // atom_a, atom_b, pos_ax, pos_ay, pos_az, pos_bx, pos_by, pos_bz,
  // spring_constant, rest_length, two zero bits
  input  logic [279:0] in_tdata,
  input  logic         in_tlast,   // last_bond
  output logic         out_tvalid,
  input  logic         out_tready,
  // force_atom_a, force_atom_b, force_x, force_y, force_z, total_value
  output logic [279:0] out_tdata,
  output logic [3:0]   out_tuser,  // record_kind
  output logic         out_tlast,  // last_of_run
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import hbfe_pkg::*;

  localparam logic signed [34:0] D_MAX = 35'sd2147483647;
  localparam logic signed [34:0] D_MIN = -35'sd2147483648;

  // minimum image on one axis, then clamp to 32 bits
  function automatic logic signed [31:0] sep(input logic signed [31:0] pb,
                                             input logic signed [31:0] pa,
                                             input logic [30:0] len,
                                             input logic [30:0] half);
    logic signed [34:0] dd, h, l;
    dd = 35'(pb) - 35'(pa);
    h  = $signed({4'b0, half});
    l  = $signed({4'b0, len});
    if (dd > h) dd = dd - l;
    else if (dd < -h) dd = dd + l;
    if (dd > D_MAX) sep = 32'h7FFFFFFF;
    else if (dd < D_MIN) sep = 32'h80000000;
    else sep = dd[31:0];
  endfunction

  // configuration
  logic [30:0] box_r [3];
  logic [30:0] half_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        box_r[i]  <= 31'd0;
        half_r[i] <= 31'd0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X:  box_r[0]  <= cfg_data;
        REG_BOX_Y:  box_r[1]  <= cfg_data;
        REG_BOX_Z:  box_r[2]  <= cfg_data;
        REG_HALF_X: half_r[0] <= cfg_data;
        REG_HALF_Y: half_r[1] <= cfg_data;
        REG_HALF_Z: half_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  st_t                st_r, st_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic               issued_r, issued_nxt;
  logic [ATOM_W-1:0]  atom_a_r, atom_b_r;
  logic signed [31:0] pa_r [3];
  logic signed [31:0] pb_r [3];
  logic [30:0]        k_r, rest_r;
  logic               last_r;
  logic signed [31:0] d_r [3];
  logic [63:0]        r2_r;
  logic [31:0]        r_r;
  logic signed [63:0] kd_r, de_r, tmp_r;
  logic signed [63:0] f_r [3];
  logic signed [63:0] energy_r;
  logic signed [63:0] hess_r [3];
  logic signed [63:0] vir_r [6];

  logic               out_tvalid_r;
  logic [279:0]       out_tdata_r;
  logic [3:0]         out_tuser_r;
  logic               out_tlast_r;

  md_req_t            md_req;
  logic               md_done;
  logic signed [63:0] md_result;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;

  logic               in_acc, out_free, unit_done;
  logic signed [33:0] dev;
  logic signed [63:0] twokd, fr, tval, h_d2e, tot_sel;
  logic [1:0]         vf, vd;

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign unit_done = (st_r == ST_SQRT) ? sq_done : md_done;

  assign dev   = $signed({2'b0, r_r}) - $signed({3'b0, rest_r});
  assign twokd = sat_add(kd_r, kd_r);
  assign fr    = sat_neg(twokd);
  assign tval  = sat_add(64'({k_r, 1'b0}) << FRAC_BITS, sat_neg(de_r));
  assign h_d2e = sat_add(md_result, de_r);

  // virial pairs: force component, separation component
  always_comb begin
    case (idx_r)
      4'd0:    begin vf = 2'd0; vd = 2'd0; end
      4'd1:    begin vf = 2'd1; vd = 2'd0; end
      4'd2:    begin vf = 2'd1; vd = 2'd1; end
      4'd3:    begin vf = 2'd2; vd = 2'd0; end
      4'd4:    begin vf = 2'd2; vd = 2'd1; end
      default: begin vf = 2'd2; vd = 2'd2; end
    endcase
  end

  always_comb begin
    case (idx_r)
      4'd0:    tot_sel = energy_r;
      4'd1:    tot_sel = hess_r[0];
      4'd2:    tot_sel = hess_r[1];
      4'd3:    tot_sel = hess_r[2];
      4'd4:    tot_sel = vir_r[0];
      4'd5:    tot_sel = vir_r[1];
      4'd6:    tot_sel = vir_r[2];
      4'd7:    tot_sel = vir_r[3];
      4'd8:    tot_sel = vir_r[4];
      default: tot_sel = vir_r[5];
    endcase
  end

  // requests to the shared multiply/divide unit and the square root unit
  always_comb begin
    md_req   = '0;
    sq_start = 1'b0;
    unique case (st_r)
      ST_SQ: begin
        md_req.op = OP_MUL;
        md_req.a  = 64'(d_r[idx_r[1:0]]);
        md_req.b  = 64'(d_r[idx_r[1:0]]);
      end
      ST_SQRT: sq_start = !issued_r;
      ST_KD: begin
        md_req.op = OP_MUL;
        md_req.a  = $signed({33'b0, k_r});
        md_req.b  = 64'(dev);
      end
      ST_EN: begin
        md_req.op = OP_MULF;
        md_req.a  = kd_r;
        md_req.b  = 64'(dev);
      end
      ST_DE: begin
        md_req.op = OP_DIV;
        md_req.a  = twokd;
        md_req.b  = 64'sd1 <<< FRAC_BITS;
      end
      ST_H1: begin
        md_req.op = OP_DIV;
        md_req.a  = tval;
        md_req.b  = 64'(d_r[idx_r[1:0]]);
      end
      ST_H2: begin
        md_req.op = OP_DIV;
        md_req.a  = tmp_r;
        md_req.b  = 64'(d_r[idx_r[1:0]]);
      end
      ST_F: begin
        md_req.op = OP_DIV;
        md_req.a  = fr;
        md_req.b  = 64'(d_r[idx_r[1:0]]);
      end
      ST_VIR: begin
        md_req.op = OP_MULF;
        md_req.a  = f_r[vf];
        md_req.b  = 64'(d_r[vd]);
      end
      default: ;
    endcase
    md_req.divisor = r_r;
    md_req.start   = !issued_r && (st_r == ST_SQ || st_r == ST_KD || st_r == ST_EN ||
                     st_r == ST_DE || st_r == ST_H1 || st_r == ST_H2 ||
                     st_r == ST_F || st_r == ST_VIR);
  end

  // next state
  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    issued_nxt = issued_r;
    if (md_req.start || sq_start) issued_nxt = 1'b1;
    if (unit_done) issued_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_SEP;
      ST_SEP: begin
        st_nxt  = ST_SQ;
        idx_nxt = 4'd0;
      end
      ST_SQ: if (md_done) begin
        if (idx_r == 4'd2) begin
          st_nxt  = ST_SQRT;
          idx_nxt = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      ST_SQRT: if (sq_done) st_nxt = ST_KD;
      ST_KD:   if (md_done) st_nxt = ST_EN;
      ST_EN:   if (md_done) st_nxt = (r_r == 32'd0) ? ST_FORCE : ST_DE;
      ST_DE: if (md_done) begin
        st_nxt  = ST_H1;
        idx_nxt = 4'd0;
      end
      ST_H1: if (md_done) st_nxt = ST_H2;
      ST_H2: if (md_done) begin
        if (idx_r == 4'd2) begin
          st_nxt  = ST_F;
          idx_nxt = 4'd0;
        end else begin
          st_nxt  = ST_H1;
          idx_nxt = idx_r + 4'd1;
        end
      end
      ST_F: if (md_done) begin
        if (idx_r == 4'd2) begin
          st_nxt  = ST_VIR;
          idx_nxt = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      ST_VIR: if (md_done) begin
        if (idx_r == 4'd5) st_nxt = ST_FORCE;
        else               idx_nxt = idx_r + 4'd1;
      end
      ST_FORCE: if (out_free) begin
        st_nxt  = last_r ? ST_TOT : ST_IDLE;
        idx_nxt = 4'd0;
      end
      ST_TOT: if (out_free) begin
        if (idx_r == 4'd9) st_nxt = ST_IDLE;
        else               idx_nxt = idx_r + 4'd1;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      idx_r    <= 4'd0;
      issued_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      idx_r    <= idx_nxt;
      issued_r <= issued_nxt;
    end
  end

  // working registers of one bond
  always_ff @(posedge clk) begin
    if (in_acc) begin
      atom_a_r <= in_tdata[11:0];
      atom_b_r <= in_tdata[23:12];
      pa_r[0]  <= in_tdata[55:24];
      pa_r[1]  <= in_tdata[87:56];
      pa_r[2]  <= in_tdata[119:88];
      pb_r[0]  <= in_tdata[151:120];
      pb_r[1]  <= in_tdata[183:152];
      pb_r[2]  <= in_tdata[215:184];
      k_r      <= in_tdata[246:216];
      rest_r   <= in_tdata[277:247];
      last_r   <= in_tlast;
    end
    if (st_r == ST_SEP) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= sep(pb_r[i], pa_r[i], box_r[i], half_r[i]);
        f_r[i] <= 64'sd0;
      end
      r2_r <= 64'd0;
    end
    if (st_r == ST_SQ && md_done)   r2_r <= r2_r + md_result;
    if (st_r == ST_SQRT && sq_done) r_r <= sq_root;
    if (st_r == ST_KD && md_done)   kd_r <= md_result;
    if (st_r == ST_DE && md_done)   de_r <= md_result;
    if (st_r == ST_H1 && md_done)   tmp_r <= md_result;
    if (st_r == ST_F && md_done)    f_r[idx_r[1:0]] <= md_result;
  end

  // running totals, cleared when the last total is written to the output register
  always_ff @(posedge clk) begin
    if (!rst_n || (st_r == ST_TOT && out_free && idx_r == 4'd9)) begin
      energy_r <= 64'sd0;
      for (int i = 0; i < 3; i++) hess_r[i] <= 64'sd0;
      for (int i = 0; i < 6; i++) vir_r[i] <= 64'sd0;
    end else begin
      if (st_r == ST_EN && md_done) energy_r <= sat_add(energy_r, md_result);
      if (st_r == ST_H2 && md_done)
        hess_r[idx_r[1:0]] <= sat_add(hess_r[idx_r[1:0]], sat_add(h_d2e, h_d2e));
      if (st_r == ST_VIR && md_done)
        vir_r[idx_r[2:0]] <= sat_add(vir_r[idx_r[2:0]], md_result);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (st_r == ST_FORCE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (st_r == ST_TOT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_FORCE && out_free) begin
      out_tdata_r <= {64'd0, f_r[2], f_r[1], f_r[0], atom_b_r, atom_a_r};
      out_tuser_r <= KIND_FORCE;
      out_tlast_r <= !last_r;
    end else if (st_r == ST_TOT && out_free) begin
      out_tdata_r <= {tot_sel, 216'd0};
      out_tuser_r <= KIND_ENERGY + idx_r;
      out_tlast_r <= (idx_r == 4'd9);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  hbfe_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .done   (md_done),
    .result (md_result)
  );

  hbfe_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (r2_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // an accepted bond always starts with the separation step
  a_accept_sep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r == ST_SEP)
    else $error("accepted bond did not enter separation step");

  // force records carry no total
  a_force_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_FORCE) |-> out_tdata[279:216] == 64'd0)
    else $error("force record with nonzero total");

  // the final total closes the run
  a_zz_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_VIR_ZZ) |-> out_tlast)
    else $error("final total without last flag");

  // no request to the arithmetic unit directly after another request
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |=> !md_req.start)
    else $error("second request issued while unit busy");

endmodule
